### sv/line_draw_page_framebuffer_defines.svh
// ----------------------------------------------------------------------------
// Line draw page framebuffer: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LINE_DRAW_PAGE_FRAMEBUFFER_DEFINES_SVH
`define LINE_DRAW_PAGE_FRAMEBUFFER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Screen geometry, opcodes and shared types of the page framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

	localparam int SCREEN_WIDTH  = 100;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = 8;
	localparam int MEM_DEPTH     = PAGE_COUNT * SCREEN_WIDTH;
	localparam int ADDR_W        = $clog2(MEM_DEPTH);
	localparam int ERR_W         = 12;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAN = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [7:0] x_start;
		logic signed [7:0] y_start;
		logic signed [7:0] x_end;
		logic signed [7:0] y_end;
		logic              ink;
		logic [2:0]        page;
		logic [6:0]        column;
		logic [7:0]        byte_in;
	} lpf_in_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       dirty;
	} lpf_out_t;

	// controller -> datapath
	typedef struct packed {
		logic ld;
		logic step;
		logic clr_en;
		logic byte_wr;
		logic byte_rd;
		logic mark_clean;
		logic out_load;
	} lpf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       clr_last;
		logic       line_last;
		logic [1:0] op;
	} lpf_stat_t;

	function automatic logic [ADDR_W-1:0] pix_addr(logic [2:0] pg, logic [6:0] col);
		pix_addr = ADDR_W'(int'(pg) * SCREEN_WIDTH + int'(col));
	endfunction

endpackage

`default_nettype wire

### sv/lpf_if.sv
// ----------------------------------------------------------------------------
// lpf_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_in_if import lpf_pkg::*; ();
	logic    valid;
	logic    ready;
	lpf_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lpf_out_if import lpf_pkg::*; ();
	logic     valid;
	logic     ready;
	lpf_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/lpf_datapath.sv
// ----------------------------------------------------------------------------
// lpf_datapath
// Request registers, Bresenham stepper, page memory with a two-stage
// read-modify-write path, dirty flag and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_datapath import lpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lpf_in_t   item,
	input  lpf_cmd_t  cmd,
	output lpf_stat_t stat,
	output lpf_out_t  result
);

	// request fields
	logic [1:0] op_q;
	logic       ink_q;
	logic [2:0] page_q;
	logic [6:0] col_q;
	logic [7:0] byte_q;

	// stepper state
	logic signed [7:0]       x_q, y_q, x1_q, y1_q;
	logic signed [ERR_W-1:0] dx_q, dyn_q, err_q;
	logic                    sx_neg_q, sy_neg_q;

	// setup terms
	logic signed [8:0]       diff_x, diff_y, abs_x, abs_y;
	logic signed [ERR_W-1:0] dx_w, dyn_w;

	// step terms
	logic signed [ERR_W:0]   e2;
	logic                    go_x, go_y;
	logic signed [ERR_W-1:0] err_nx;
	logic                    on_scr;
	logic [ADDR_W-1:0]       pix_a, byte_a;
	logic                    col_ok;

	// memory and rmw pipe
	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rdata_q;
	logic              rd_en, we;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [7:0]        wdata;
	logic              v_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic              fwd_v_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [7:0]        fwd_data_q;
	logic [7:0]        base, new_byte;

	logic [ADDR_W-1:0] clr_cnt_q;
	logic              dirty_q;

	// setup from the incoming request
	always_comb begin
		diff_x = 9'(item.x_end) - 9'(item.x_start);
		diff_y = 9'(item.y_end) - 9'(item.y_start);
		abs_x  = diff_x[8] ? -diff_x : diff_x;
		abs_y  = diff_y[8] ? -diff_y : diff_y;
		dx_w   = ERR_W'(abs_x);
		dyn_w  = -ERR_W'(abs_y);
	end

	// one Bresenham step
	always_comb begin
		e2     = {err_q, 1'b0};
		go_x   = e2 >= (ERR_W+1)'(dyn_q);
		go_y   = e2 <= (ERR_W+1)'(dx_q);
		err_nx = err_q + (go_x ? dyn_q : '0) + (go_y ? dx_q : '0);
		on_scr = !x_q[7] && (int'(x_q[6:0]) < SCREEN_WIDTH) &&
			!y_q[7] && (int'(y_q[6:0]) < SCREEN_HEIGHT);
		pix_a  = pix_addr(y_q[5:3], x_q[6:0]);
		byte_a = pix_addr(page_q, col_q);
		col_ok = int'(col_q) < SCREEN_WIDTH;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q     <= item.opcode;
			ink_q    <= item.ink;
			page_q   <= item.page;
			col_q    <= item.column;
			byte_q   <= item.byte_in;
			x_q      <= item.x_start;
			y_q      <= item.y_start;
			x1_q     <= item.x_end;
			y1_q     <= item.y_end;
			dx_q     <= dx_w;
			dyn_q    <= dyn_w;
			err_q    <= dx_w + dyn_w;
			sx_neg_q <= !(item.x_start < item.x_end);
			sy_neg_q <= !(item.y_start < item.y_end);
		end else if (cmd.step) begin
			err_q <= err_nx;
			if (go_x) begin
				x_q <= x_q + (sx_neg_q ? 8'shFF : 8'sh01);
			end
			if (go_y) begin
				y_q <= y_q + (sy_neg_q ? 8'shFF : 8'sh01);
			end
		end
	end

	// stage B merge; forward the previous pixel's write, which the read missed
	always_comb begin
		base     = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_q;
		new_byte = ink_q ? (base | mask_s1) : (base & ~mask_s1);
	end

	always_comb begin
		rd_en = (cmd.step && on_scr) || (cmd.byte_rd && col_ok);
		raddr = cmd.step ? pix_a : byte_a;
		we    = 1'b0;
		waddr = byte_a;
		wdata = byte_q;
		if (cmd.clr_en) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (v_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = new_byte;
		end else if (cmd.byte_wr && col_ok) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fwd_v_q   <= 1'b0;
			clr_cnt_q <= '0;
			dirty_q   <= 1'b0;
		end else begin
			v_s1    <= cmd.step && on_scr;
			fwd_v_q <= v_s1;
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (cmd.mark_clean) begin
				dirty_q <= 1'b0;
			end else if (v_s1) begin
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= pix_a;
		mask_s1    <= 8'(1) << y_q[2:0];
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.read_byte <= (op_q == OP_READ && col_ok) ? rdata_q : 8'h00;
			result.dirty     <= dirty_q;
		end
	end

	assign stat.clr_last  = clr_cnt_q == ADDR_W'(MEM_DEPTH - 1);
	assign stat.line_last = (x_q == x1_q) && (y_q == y1_q);
	assign stat.op        = op_q;

endmodule

`default_nettype wire

### sv/lpf_ctrl.sv
// ----------------------------------------------------------------------------
// lpf_ctrl
// Sequencer: clearing pass, request intake, line walk, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_ctrl import lpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lpf_stat_t stat,
	output lpf_cmd_t  cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_LINE  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld   = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nx = ST_DONE;
				case (stat.op)
					OP_DRAW:  state_nx       = ST_LINE;
					OP_WRITE: cmd.byte_wr    = 1'b1;
					OP_READ:  cmd.byte_rd    = 1'b1;
					default:  cmd.mark_clean = 1'b1;
				endcase
			end
			ST_LINE: begin
				cmd.step = 1'b1;
				if (stat.line_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/line_draw_page_framebuffer.sv
// ----------------------------------------------------------------------------
// line_draw_page_framebuffer
// Monochrome 8-page framebuffer with a Bresenham line rasterizer.
// ----------------------------------------------------------------------------
// Usage:
//  - cmd carries one request per valid/ready handshake: draw line, write page
//    byte, read page byte or mark clean. res returns exactly one result per
//    request, in order: read_byte (0 unless a read) and the dirty flag.
//  - Byte requests and mark clean: after accept, the EXEC and DONE states precede res.valid.
//  - Draw line: N = max(|dx|, |dy|) + 1 pixels (up to 256), walked in LINE, then DRAIN and DONE.
//    The walk places one pixel per cycle; the page memory's single write
//    port does one read-modify-write per cycle, with the previous pixel's
//    byte forwarded when two pixels share a page byte.
//  - One request is worked at a time; the next is taken in the cycle after the
//    previous result is handed to the output register.
//  - Reset: the page memory is cleared to white by a pass over all 8 * SCREEN_WIDTH
//    bytes (800 at the default width); cmd.ready stays low until it ends.
//  - A stalled res holds its result; one more request may be accepted and
//    worked meanwhile, and its result waits until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module line_draw_page_framebuffer import lpf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lpf_in_if.sink    cmd,
	lpf_out_if.source res
);

	lpf_cmd_t  ctl_cmd;
	lpf_stat_t dp_stat;

	// sequencer
	lpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	// stepper, page memory and result registers
	lpf_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd.data),
		.cmd    (ctl_cmd),
		.stat   (dp_stat),
		.result (res.data)
	);

endmodule

`default_nettype wire

### sv/lpf_checker.sv
// ----------------------------------------------------------------------------
// lpf_checker
// Port-level checks of request/result ordering, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_draw_page_framebuffer_defines.svh"

module lpf_checker import lpf_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input logic     res_valid,
	input logic     res_ready,
	input lpf_out_t res_data
);

	logic       acc, fire;
	logic [1:0] pend_q;

	assign acc  = cmd_valid && cmd_ready;
	assign fire = res_valid && res_ready;

	// requests accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(acc) - 2'(fire);
		end
	end

	`LPF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, acc, !cmd_ready, "ready held after accept")
	`LPF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result changed")
	`LPF_ASSERT_NOW(a_no_orphan, clk, arst_n, res_valid, pend_q != 2'd0, "result without request")
	`LPF_ASSERT_NOW(a_max_pend, clk, arst_n, acc, pend_q <= 2'd1, "too many requests in flight")

endmodule

bind line_draw_page_framebuffer lpf_checker u_lpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

`default_nettype wire

### tb/sv/line_draw_page_framebuffer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_draw_page_framebuffer_test
// Self-checking bench for the page framebuffer. A scoreboard keeps its own
// copy of the frame and the dirty bit and predicts every result. Requests are
// a short directed list followed by randomized draw/readback sequences and
// byte noise. Both sides throttle at random, and one long result stall is
// included to back up the request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module line_draw_page_framebuffer_test;
	import lpf_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int RANDOM_REQS     = 1850;
	localparam int HOLD_OFF_CYCLES = 400;
	// Worst case per request is a 256-pixel line plus overhead and stalls;
	// the limit covers about 2000 such requests several times over.
	localparam int CYCLE_LIMIT     = 3_000_000;
	// Drain margin after the last result; the longest draw walks 256 pixels.
	localparam int DRAIN_CYCLES    = 300;

	// ------------------------------------------------------------------------
	// Scoreboard: frame model, dirty flag, queue of expected results
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		logic [7:0] frame [PAGE_COUNT][SCREEN_WIDTH];
		bit         dirty;
		lpf_out_t   want_q[$];
		int         mismatches;

		function new();
			foreach (frame[p, c])
				frame[p][c] = 8'h00;
			dirty      = 1'b0;
			mismatches = 0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		// off-screen pixels are dropped, but any on-screen pixel marks dirty
		function void plot_pixel(int x, int y, bit ink);
			if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
				return;
			if (ink)
				frame[y / 8][x] = frame[y / 8][x] | (8'h01 << (y % 8));
			else
				frame[y / 8][x] = frame[y / 8][x] & ~(8'h01 << (y % 8));
			dirty = 1'b1;
		endfunction

		// integer Bresenham, both endpoints included, any octant
		function void rasterize(int x0, int y0, int x1, int y1, bit ink);
			int run;
			int rise;
			int stx;
			int sty;
			int acc;
			int acc2;
			run  = (x1 > x0) ? x1 - x0 : x0 - x1;
			rise = (y1 > y0) ? y0 - y1 : y1 - y0;
			stx  = (x0 < x1) ? 1 : -1;
			sty  = (y0 < y1) ? 1 : -1;
			acc  = run + rise;
			forever begin
				plot_pixel(x0, y0, ink);
				if (x0 == x1 && y0 == y1)
					break;
				acc2 = 2 * acc;
				if (acc2 >= rise) begin
					acc += rise;
					x0  += stx;
				end
				if (acc2 <= run) begin
					acc += run;
					y0  += sty;
				end
			end
		endfunction

		function void note_request(lpf_in_t r);
			lpf_out_t want;
			want.read_byte = 8'h00;
			case (r.opcode)
				OP_DRAW: begin
					rasterize(int'($signed(r.x_start)), int'($signed(r.y_start)),
						int'($signed(r.x_end)), int'($signed(r.y_end)), r.ink);
				end
				OP_WRITE: begin
					if (r.column < SCREEN_WIDTH)
						frame[r.page][r.column] = r.byte_in;
				end
				OP_READ: begin
					if (r.column < SCREEN_WIDTH)
						want.read_byte = frame[r.page][r.column];
				end
				OP_CLEAN: begin
					dirty = 1'b0;
				end
			endcase
			want.dirty = dirty;
			want_q.push_back(want);
		endfunction

		task report(string what, int got, int want);
			$display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_result(lpf_out_t got);
			lpf_out_t want;
			if (want_q.size() == 0) begin
				report("result with no request pending", got, 0);
				return;
			end
			want = want_q.pop_front();
			if (got.read_byte !== want.read_byte)
				report("read_byte mismatch", got.read_byte, want.read_byte);
			if (got.dirty !== want.dirty)
				report("dirty mismatch", got.dirty, want.dirty);
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	lpf_in_if  cmd ();
	lpf_out_if res ();

	line_draw_page_framebuffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	frame_scoreboard sb;

	// throttle knobs, percent of cycles each side sits idle
	int src_idle_pct  = 20;
	int sink_idle_pct = 20;
	// one-shot request for a long result stall, served by the sink process
	bit hold_off_req  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Request side helpers
	// ------------------------------------------------------------------------

	// every field random, so unused fields toggle all their bits too
	function automatic lpf_in_t noise_request();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(lpf_in_t)-1:0];
	endfunction

	function automatic lpf_in_t mk_draw(int x0, int y0, int x1, int y1, bit ink);
		lpf_in_t r;
		r         = noise_request();
		r.opcode  = OP_DRAW;
		r.x_start = 8'(x0);
		r.y_start = 8'(y0);
		r.x_end   = 8'(x1);
		r.y_end   = 8'(y1);
		r.ink     = ink;
		return r;
	endfunction

	function automatic lpf_in_t mk_byte(logic [1:0] op, int pg, int col, int val);
		lpf_in_t r;
		r         = noise_request();
		r.opcode  = op;
		r.page    = 3'(pg);
		r.column  = 7'(col);
		r.byte_in = 8'(val);
		return r;
	endfunction

	// endpoints mostly around the screen, sometimes anywhere in range
	function automatic int pick_col();
		if ($urandom_range(99) < 85)
			return $urandom_range(139) - 20;
		return $urandom_range(255) - 128;
	endfunction

	function automatic int pick_row();
		if ($urandom_range(99) < 85)
			return $urandom_range(103) - 20;
		return $urandom_range(255) - 128;
	endfunction

	// Called just after a rising edge. valid gets one assignment per step:
	// either dropped for an idle cycle or (re)asserted with the new request.
	task automatic send_request(lpf_in_t r);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= r;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// ------------------------------------------------------------------------
	// Result side: check accepted results, throttle ready, long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				sb.check_result(res.data);
			if (hold_off_req) begin
				hold_left    = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// watchdog: runs out only if the block hangs
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main stimulus
	// ------------------------------------------------------------------------
	initial begin
		int      sent;
		int      pick;
		int      x0, y0, x1, y1;
		int      span, t, px, py, reads;
		bit      pressure_done;
		lpf_in_t r;

		sb        = new();
		arst_n    = 1'b0;
		cmd.valid = 1'b0;
		cmd.data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// freshly reset frame reads white, dirty low
		send_request(mk_byte(OP_READ, 0, 0, 8'h00));
		// lines wholly off screen leave dirty alone
		send_request(mk_draw(-128, -128, -1, -50, 1'b1));
		send_request(mk_draw(SCREEN_WIDTH, 0, 127, 127, 1'b1));
		// byte writes: edge columns, out-of-range columns dropped, dirty untouched
		send_request(mk_byte(OP_WRITE, 7, SCREEN_WIDTH - 1, 8'hFF));
		send_request(mk_byte(OP_WRITE, 0, 0, 8'hA5));
		send_request(mk_byte(OP_WRITE, 3, SCREEN_WIDTH, 8'h5A));
		send_request(mk_byte(OP_WRITE, 7, 127, 8'hFF));
		send_request(mk_byte(OP_READ, 7, SCREEN_WIDTH - 1, 8'h00));
		send_request(mk_byte(OP_READ, 3, SCREEN_WIDTH, 8'h00));
		send_request(mk_byte(OP_READ, 7, 127, 8'h00));
		send_request(mk_byte(OP_READ, 0, 0, 8'h00));
		// single-point line, then readback
		send_request(mk_draw(5, 5, 5, 5, 1'b1));
		send_request(mk_byte(OP_READ, 0, 5, 8'h00));
		// clean, then redraw a pixel that already holds the ink: still dirty
		send_request(mk_byte(OP_CLEAN, 0, 0, 8'h00));
		send_request(mk_draw(5, 5, 5, 5, 1'b1));
		// full diagonal, steep reversed, shallow reversed, vertical crossing the screen
		send_request(mk_draw(0, 0, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1'b1));
		send_request(mk_draw(50, SCREEN_HEIGHT - 1, 45, 0, 1'b1));
		send_request(mk_draw(SCREEN_WIDTH - 1, 10, 0, 10, 1'b1));
		send_request(mk_draw(20, -128, 20, 127, 1'b1));
		send_request(mk_byte(OP_READ, 3, 20, 8'h00));
		send_request(mk_byte(OP_READ, 1, 47, 8'h00));
		// white lines at the coordinate extremes, both directions
		send_request(mk_draw(-128, 127, 127, -128, 1'b0));
		send_request(mk_draw(127, 127, -128, -128, 1'b0));
		send_request(mk_byte(OP_READ, 1, 10, 8'h00));
		send_request(mk_byte(OP_CLEAN, 0, 0, 8'h00));

		// --- random part ---
		sent          = 0;
		pressure_done = 1'b0;
		while (sent < RANDOM_REQS) begin
			// a long stretch with both sides running flat out
			if (sent >= 700 && sent < 1000) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct  = 20;
				sink_idle_pct = 20;
			end
			// once: stall results for a long time while requests keep coming
			if (!pressure_done && sent >= 1200) begin
				hold_off_req  = 1'b1;
				pressure_done = 1'b1;
			end

			pick = $urandom_range(99);
			if (pick < 35) begin
				// draw, then read back a few bytes along the path
				x0 = pick_col();
				y0 = pick_row();
				x1 = pick_col();
				y1 = pick_row();
				send_request(mk_draw(x0, y0, x1, y1, $urandom_range(1)));
				sent++;
				span = (x1 > x0) ? x1 - x0 : x0 - x1;
				if (((y1 > y0) ? y1 - y0 : y0 - y1) > span)
					span = (y1 > y0) ? y1 - y0 : y0 - y1;
				reads = $urandom_range(3, 1);
				repeat (reads) begin
					t  = $urandom_range(span);
					px = (span == 0) ? x0 : x0 + ((x1 - x0) * t) / span;
					py = (span == 0) ? y0 : y0 + ((y1 - y0) * t) / span;
					if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT)
						r = mk_byte(OP_READ, py / 8, px, 0);
					else
						r = mk_byte(OP_READ, $urandom_range(7), $urandom_range(127), 0);
					send_request(r);
					sent++;
				end
			end else if (pick < 55) begin
				// byte write, often read straight back
				r = mk_byte(OP_WRITE, $urandom_range(7), $urandom_range(127),
					$urandom_range(255));
				send_request(r);
				sent++;
				if ($urandom_range(1)) begin
					send_request(mk_byte(OP_READ, r.page, r.column, 0));
					sent++;
				end
			end else if (pick < 90) begin
				send_request(mk_byte(OP_READ, $urandom_range(7), $urandom_range(127), 0));
				sent++;
			end else begin
				send_request(mk_byte(OP_CLEAN, 0, 0, 0));
				sent++;
			end
		end
		cmd.valid <= 1'b0;

		// --- drain ---
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
